// ----- src/cds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 12;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [CountW-1:0] MAX_STEPS = 12'd4095;

  localparam logic [YearW-1:0] MIN_YEAR_RST = 14'd1900;
  localparam logic [YearW-1:0] MAX_YEAR_RST = 14'd10000;

  // y divisible by 25 <=> (y * 25^-1 mod 2^14) <= floor((2^14-1)/25)
  localparam logic [YearW-1:0] INV25       = 14'd7209;
  localparam logic [YearW-1:0] DIV25_LIMIT = 14'd655;

  localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
  localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MonthW-1:0] MONTH_APR = 4'd4;
  localparam logic [MonthW-1:0] MONTH_JUN = 4'd6;
  localparam logic [MonthW-1:0] MONTH_SEP = 4'd9;
  localparam logic [MonthW-1:0] MONTH_NOV = 4'd11;
  localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;

  localparam logic [DayW-1:0] DAY_FIRST = 5'd1;
  localparam logic [DayW-1:0] DAY_31    = 5'd31;
  localparam logic [DayW-1:0] DAY_30    = 5'd30;
  localparam logic [DayW-1:0] DAY_29    = 5'd29;
  localparam logic [DayW-1:0] DAY_28    = 5'd28;

  localparam logic [0:0] REG_MIN_YEAR = 1'b0;
  localparam logic [0:0] REG_MAX_YEAR = 1'b1;

  localparam logic ACT_FWD = 1'b0;
  localparam logic ACT_BWD = 1'b1;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    len = DAY_31;
    case (m) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAY_30;
      MONTH_FEB: len = leap ? DAY_29 : DAY_28;
      default: len = DAY_31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- src/calendar_date_step_core.sv -----
// Sequence: ST_PREP lets the registered leap-year flag settle, then ST_RUN steps one
//   day at a time and the result_valid_o strobe follows the last step or an invalid date.
// Throughput: a new word is taken only while idle; a single day-step unit is
//   reused every cycle and busy stays high until the result is issued.
// Reset: asynchronous, active low; clears the sequencer and the result strobe and
//   sets min_year to 1900 and max_year to 10000. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_step_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       action_i,
  input  wire logic [cds_pkg::DayW-1:0]   day_in_i,
  input  wire logic [cds_pkg::MonthW-1:0] month_in_i,
  input  wire logic [cds_pkg::YearW-1:0]  year_in_i,
  input  wire logic [cds_pkg::CountW-1:0] step_count_i,
  output logic                            result_valid_o,
  output logic      [cds_pkg::DayW-1:0]   day_out_o,
  output logic      [cds_pkg::MonthW-1:0] month_out_o,
  output logic      [cds_pkg::YearW-1:0]  year_out_o,
  output logic                            status_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cds_pkg::AddrW-1:0]  paddr,
  input  wire logic [cds_pkg::DataW-1:0]  pwdata,
  output logic      [cds_pkg::DataW-1:0]  prdata,
  output logic                            pready
);
  import cds_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              act_q, act_d;
  date_t             date_q, date_d;
  date_t             res_q, res_d;
  logic              status_q, status_d;
  logic              rvalid_q, rvalid_d;

  logic [YearW-1:0]  min_year, max_year;
  logic              leap;
  logic              step_valid;
  date_t             step_date;
  logic [CountW-1:0] steps_sat;

  assign pready = 1'b1;

  cds_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_o   (prdata),
    .min_year_o (min_year),
    .max_year_o (max_year)
  );

  cds_leap u_leap (
    .clk_i  (clk_i),
    .year_i (date_q.year),
    .leap_o (leap)
  );

  cds_step u_step (
    .action_i   (act_q),
    .date_i     (date_q),
    .leap_i     (leap),
    .min_year_i (min_year),
    .max_year_i (max_year),
    .valid_o    (step_valid),
    .date_o     (step_date)
  );

  assign steps_sat = (step_count_i > MAX_STEPS) ? MAX_STEPS : step_count_i;
  assign busy      = (state_q != ST_IDLE);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    act_d    = act_q;
    date_d   = date_q;
    res_d    = res_q;
    status_d = status_q;
    rvalid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          act_d        = action_i;
          date_d.day   = day_in_i;
          date_d.month = month_in_i;
          date_d.year  = year_in_i;
          cnt_d        = steps_sat;
          state_d      = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (cnt_q == '0) begin
          res_d    = date_q;
          status_d = 1'b0;
          rvalid_d = 1'b1;
          state_d  = ST_IDLE;
        end else if (!step_valid) begin
          res_d    = '0;
          status_d = 1'b1;
          rvalid_d = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          date_d = step_date;
          cnt_d  = cnt_q - {{(CountW-1){1'b0}}, 1'b1};
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    act_q    <= act_d;
    date_q   <= date_d;
    res_q    <= res_d;
    status_q <= status_d;
  end

  assign result_valid_o = rvalid_q;
  assign day_out_o      = res_q.day;
  assign month_out_o    = res_q.month;
  assign year_out_o     = res_q.year;
  assign status_o       = status_q;

endmodule

`default_nettype wire

// ----- src/cds_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cds_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel_i,
  input  wire logic                      penable_i,
  input  wire logic                      pwrite_i,
  input  wire logic [cds_pkg::AddrW-1:0] paddr_i,
  input  wire logic [cds_pkg::DataW-1:0] pwdata_i,
  output logic      [cds_pkg::DataW-1:0] prdata_o,
  output logic      [cds_pkg::YearW-1:0] min_year_o,
  output logic      [cds_pkg::YearW-1:0] max_year_o
);
  import cds_pkg::*;

  logic [YearW-1:0] min_year_q, min_year_d;
  logic [YearW-1:0] max_year_q, max_year_d;
  logic             wr_en;
  logic [0:0]       reg_sel;

  assign wr_en   = psel_i & penable_i & pwrite_i;
  assign reg_sel = paddr_i[2];

  always_comb begin
    min_year_d = min_year_q;
    max_year_d = max_year_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_MIN_YEAR: min_year_d = pwdata_i[YearW-1:0];
        REG_MAX_YEAR: max_year_d = pwdata_i[YearW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= MIN_YEAR_RST;
      max_year_q <= MAX_YEAR_RST;
    end else begin
      min_year_q <= min_year_d;
      max_year_q <= max_year_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_YEAR: prdata_o = {{(DataW-YearW){1'b0}}, min_year_q};
      REG_MAX_YEAR: prdata_o = {{(DataW-YearW){1'b0}}, max_year_q};
      default:      prdata_o = '0;
    endcase
  end

  assign min_year_o = min_year_q;
  assign max_year_o = max_year_q;

endmodule

`default_nettype wire

// ----- src/cds_leap.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cds_leap (
  input  wire logic                      clk_i,
  input  wire logic [cds_pkg::YearW-1:0] year_i,
  output logic                           leap_o
);
  import cds_pkg::*;

  logic [YearW-1:0] prod;
  logic             div4, div16, div25;
  logic             leap_q, leap_d;

  assign prod  = year_i * INV25;
  assign div25 = (prod <= DIV25_LIMIT);
  assign div4  = (year_i[1:0] == 2'b00);
  assign div16 = (year_i[3:0] == 4'b0000);

  // div by 100 = div4 & div25, div by 400 = div16 & div25
  assign leap_d = div4 & (~div25 | div16);

  always_ff @(posedge clk_i) begin
    leap_q <= leap_d;
  end

  assign leap_o = leap_q;

endmodule

`default_nettype wire

// ----- src/cds_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cds_step (
  input  wire logic                      action_i,
  input  wire cds_pkg::date_t            date_i,
  input  wire logic                      leap_i,
  input  wire logic [cds_pkg::YearW-1:0] min_year_i,
  input  wire logic [cds_pkg::YearW-1:0] max_year_i,
  output logic                           valid_o,
  output cds_pkg::date_t                 date_o
);
  import cds_pkg::*;

  logic [DayW-1:0]   len;
  logic [MonthW-1:0] prev_month;
  logic              year_ok, month_ok, day_ok;

  assign len        = month_len(date_i.month, leap_i);
  assign prev_month = date_i.month - MONTH_JAN;

  assign year_ok  = (date_i.year >= min_year_i) && (date_i.year <= max_year_i);
  assign month_ok = (date_i.month >= MONTH_JAN) && (date_i.month <= MONTH_DEC);
  assign day_ok   = (date_i.day >= DAY_FIRST) && (date_i.day <= len);
  assign valid_o  = year_ok & month_ok & day_ok;

  always_comb begin
    date_o = date_i;
    if (action_i == ACT_FWD) begin
      if (date_i.day < len) begin
        date_o.day = date_i.day + DAY_FIRST;
      end else if (date_i.month < MONTH_DEC) begin
        date_o.day   = DAY_FIRST;
        date_o.month = date_i.month + MONTH_JAN;
      end else begin
        date_o.day   = DAY_FIRST;
        date_o.month = MONTH_JAN;
        date_o.year  = date_i.year + {{(YearW-1){1'b0}}, 1'b1};
      end
    end else begin
      if (date_i.day > DAY_FIRST) begin
        date_o.day = date_i.day - DAY_FIRST;
      end else if (date_i.month > MONTH_JAN) begin
        date_o.month = prev_month;
        date_o.day   = month_len(prev_month, leap_i);
      end else begin
        date_o.day   = DAY_31;
        date_o.month = MONTH_DEC;
        date_o.year  = date_i.year - {{(YearW-1){1'b0}}, 1'b1};
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import cds_pkg::*;

  localparam logic [AddrW-1:0] MIN_YEAR_ADDR = {REG_MIN_YEAR, 2'b00};
  localparam logic [AddrW-1:0] MAX_YEAR_ADDR = {REG_MAX_YEAR, 2'b00};

  typedef struct packed {
    date_t date;
    logic  invalid;
  } step_result_t;

  class date_scoreboard;
    logic [YearW-1:0] lo_year;
    logic [YearW-1:0] hi_year;
    step_result_t     expected_q[$];
    int unsigned      errors;

    function new();
      lo_year = MIN_YEAR_RST;
      hi_year = MAX_YEAR_RST;
      errors  = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function bit leap_year(logic [YearW-1:0] y);
      int yi;
      yi = y;
      return ((yi % 4 == 0) && (yi % 100 != 0)) || (yi % 400 == 0);
    endfunction

    function logic [DayW-1:0] days_in(logic [MonthW-1:0] m, logic [YearW-1:0] y);
      case (m)
        MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return DAY_30;
        MONTH_FEB: return leap_year(y) ? DAY_29 : DAY_28;
        default: return DAY_31;
      endcase
    endfunction

    function bit date_ok(date_t dt);
      if (dt.year < lo_year || dt.year > hi_year) return 1'b0;
      if (dt.month < MONTH_JAN || dt.month > MONTH_DEC) return 1'b0;
      return (dt.day >= DAY_FIRST) && (dt.day <= days_in(dt.month, dt.year));
    endfunction

    // walk the date one day at a time, validating before every step
    function void note_word(logic back, date_t start_date, logic [CountW-1:0] steps);
      step_result_t res;
      date_t        cur;
      int           n;
      int           i;
      cur         = start_date;
      res.invalid = 1'b0;
      n           = (steps > MAX_STEPS) ? MAX_STEPS : steps;
      for (i = 0; i < n && !res.invalid; i++) begin
        if (!date_ok(cur)) begin
          res.invalid = 1'b1;
        end else if (back == ACT_FWD) begin
          if (cur.day < days_in(cur.month, cur.year)) begin
            cur.day = cur.day + 1'b1;
          end else if (cur.month < MONTH_DEC) begin
            cur.day   = DAY_FIRST;
            cur.month = cur.month + 1'b1;
          end else begin
            cur.day   = DAY_FIRST;
            cur.month = MONTH_JAN;
            cur.year  = cur.year + 1'b1;
          end
        end else begin
          if (cur.day > DAY_FIRST) begin
            cur.day = cur.day - 1'b1;
          end else if (cur.month > MONTH_JAN) begin
            cur.month = cur.month - 1'b1;
            cur.day   = days_in(cur.month, cur.year);
          end else begin
            cur.day   = DAY_31;
            cur.month = MONTH_DEC;
            cur.year  = cur.year - 1'b1;
          end
        end
      end
      res.date = res.invalid ? '0 : cur;
      expected_q.push_back(res);
    endfunction

    function void check_word(date_t got, logic got_invalid);
      step_result_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected word: day %0d month %0d year %0d status %0d",
                       got.day, got.month, got.year, got_invalid));
        return;
      end
      want = expected_q.pop_front();
      if (got.day !== want.date.day || got.month !== want.date.month ||
          got.year !== want.date.year || got_invalid !== want.invalid) begin
        flag($sformatf("mismatch: exp %0d/%0d/%0d st %0d, got %0d/%0d/%0d st %0d",
                       want.date.day, want.date.month, want.date.year, want.invalid,
                       got.day, got.month, got.year, got_invalid));
      end
    endfunction
  endclass

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic              busy;
  logic              action_i     = 1'b0;
  logic [DayW-1:0]   day_in_i     = '0;
  logic [MonthW-1:0] month_in_i   = '0;
  logic [YearW-1:0]  year_in_i    = '0;
  logic [CountW-1:0] step_count_i = '0;
  logic              result_valid_o;
  logic [DayW-1:0]   day_out_o;
  logic [MonthW-1:0] month_out_o;
  logic [YearW-1:0]  year_out_o;
  logic              status_o;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [AddrW-1:0]  paddr        = '0;
  logic [DataW-1:0]  pwdata       = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  date_scoreboard sb;
  int             burst_left = 0;

  calendar_date_step_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .day_in_i       (day_in_i),
    .month_in_i     (month_in_i),
    .year_in_i      (year_in_i),
    .step_count_i   (step_count_i),
    .result_valid_o (result_valid_o),
    .day_out_o      (day_out_o),
    .month_out_o    (month_out_o),
    .year_out_o     (year_out_o),
    .status_o       (status_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        sb.check_word('{day: day_out_o, month: month_out_o, year: year_out_o}, status_o);
      end
      if (start && !busy) begin
        sb.note_word(action_i, '{day: day_in_i, month: month_in_i, year: year_in_i},
                     step_count_i);
      end
    end
  end

  function automatic int pick_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(4, 12);
    return $urandom_range(0, 17);
  endfunction

  task automatic idle_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start        <= 1'b0;
      action_i     <= $urandom;
      day_in_i     <= $urandom;
      month_in_i   <= $urandom;
      year_in_i    <= $urandom;
      step_count_i <= $urandom;
    end
  endtask

  task automatic send_word(logic back, int d, int m, int y, int steps);
    @(negedge clk_i);
    start        <= 1'b1;
    action_i     <= back;
    day_in_i     <= d[DayW-1:0];
    month_in_i   <= m[MonthW-1:0];
    year_in_i    <= y[YearW-1:0];
    step_count_i <= steps[CountW-1:0];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    idle_sender(pick_gap());
  endtask

  task automatic drain();
    idle_sender(1);
    while (sb.expected_q.size() != 0 || busy) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [AddrW-1:0] addr, logic [YearW-1:0] value);
    logic [DataW-1:0] data;
    data             = $urandom;
    data[YearW-1:0]  = value;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == MIN_YEAR_ADDR) sb.lo_year = value;
    else sb.hi_year = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check(logic [AddrW-1:0] addr, logic [YearW-1:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[YearW-1:0] !== want) begin
      sb.flag($sformatf("register at %0d: exp %0d, got %0d", addr, want,
                        prdata[YearW-1:0]));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_bounds(int lo, int hi);
    drain();
    reg_write(MIN_YEAR_ADDR, lo[YearW-1:0]);
    reg_write(MAX_YEAR_ADDR, hi[YearW-1:0]);
    reg_check(MIN_YEAR_ADDR, lo[YearW-1:0]);
    reg_check(MAX_YEAR_ADDR, hi[YearW-1:0]);
  endtask

  // mostly valid in-range dates, biased toward the bounds, month ends and year ends
  task automatic send_random();
    int lo;
    int hi;
    int y;
    int m;
    int d;
    int ofs;
    int sel;
    int r;
    int steps;
    lo = sb.lo_year;
    hi = sb.hi_year;
    m  = $urandom_range(1, 12);
    if ($urandom_range(0, 99) < 15) begin
      y = $urandom_range(0, 16383);
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end else begin
      if (lo <= hi) begin
        sel = $urandom_range(0, 9);
        ofs = $urandom_range(0, (hi - lo < 12) ? hi - lo : 12);
        if (sel == 0) y = lo + ofs;
        else if (sel == 1) y = hi - ofs;
        else y = $urandom_range(lo, hi);
      end else begin
        y = $urandom_range(0, 16383);
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        m = MONTH_DEC;
        d = DAY_31;
      end else if (sel == 1) begin
        m = MONTH_JAN;
        d = DAY_FIRST;
      end else if (sel == 2) begin
        d = sb.days_in(m[MonthW-1:0], y[YearW-1:0]);
      end else begin
        d = $urandom_range(1, sb.days_in(m[MonthW-1:0], y[YearW-1:0]));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 8) steps = 0;
    else if (r < 65) steps = $urandom_range(1, 40);
    else if (r < 88) steps = $urandom_range(41, 500);
    else steps = $urandom_range(501, 4095);
    send_word($urandom_range(0, 1), d, m, y, steps);
    if ($urandom_range(0, 19) == 0) drain();
  endtask

  initial begin
    #50_000_000;
    $display("FAIL calendar_date_step_core");
    $finish;
  end

  initial begin
    int lo;
    int hi;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset bounds 1900..10000
    send_word(ACT_FWD, 0, 0, 0, 0);
    send_word(ACT_BWD, 31, 15, 16383, 0);
    send_word(ACT_FWD, 31, 12, 1999, 1);
    send_word(ACT_BWD, 1, 1, 2000, 1);
    send_word(ACT_FWD, 28, 2, 2000, 2);
    send_word(ACT_FWD, 28, 2, 1900, 1);
    send_word(ACT_BWD, 1, 3, 2100, 1);
    send_word(ACT_BWD, 1, 3, 2024, 1);
    send_word(ACT_FWD, 29, 2, 1900, 1);
    send_word(ACT_FWD, 31, 4, 2001, 1);
    send_word(ACT_FWD, 1, 13, 2001, 1);
    send_word(ACT_FWD, 0, 5, 2001, 1);
    send_word(ACT_BWD, 1, 1, 1900, 2);
    send_word(ACT_FWD, 30, 12, 10000, 2);
    send_word(ACT_FWD, 30, 12, 10000, 3);
    send_word(ACT_FWD, 1, 1, 1900, 4095);
    send_word(ACT_BWD, 31, 12, 9999, 4095);

    // full year range: wrap at the ends of the year counter
    set_bounds(0, 16383);
    send_word(ACT_FWD, 31, 12, 16383, 2);
    send_word(ACT_BWD, 1, 1, 0, 1);
    send_word(ACT_BWD, 29, 2, 0, 4095);

    // reversed bounds
    set_bounds(16383, 0);
    send_word(ACT_FWD, 1, 6, 5000, 1);
    send_word(ACT_FWD, 1, 6, 5000, 0);

    set_bounds(2024, 2024);
    send_word(ACT_FWD, 30, 12, 2024, 3);

    set_bounds(MIN_YEAR_RST, MAX_YEAR_RST);
    repeat (25) send_random();
    set_bounds(0, 16383);
    repeat (25) send_random();
    lo = $urandom_range(0, 16383);
    hi = lo + $urandom_range(0, 3000);
    if (hi > 16383) hi = 16383;
    set_bounds(lo, hi);
    repeat (25) send_random();
    set_bounds(16383 - $urandom_range(0, 3), 16383);
    repeat (20) send_random();
    lo = $urandom_range(1, 16383);
    set_bounds(lo, $urandom_range(0, lo - 1));
    repeat (20) send_random();

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS calendar_date_step_core");
    end else begin
      $display("FAIL calendar_date_step_core");
    end
    $finish;
  end

endmodule
